### hw/rtl/segy_pkg.sv
// ----------------------------------------------------------------------------
// segy_pkg
// shared types, constants and conversion functions for the trace word decoder
// ----------------------------------------------------------------------------
package segy_pkg;

    localparam int unsigned HDR_WORDS = 60;
    localparam int unsigned POS_W     = 17;

    localparam logic [1:0] CFG_BIG_ENDIAN  = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_FMT  = 2'd1;
    localparam logic [1:0] CFG_SAMPLES     = 2'd2;

    localparam logic [1:0] FMT_IBM    = 2'd0;
    localparam logic [1:0] FMT_INT    = 2'd1;
    localparam logic [1:0] FMT_IEEE   = 2'd2;
    localparam logic [1:0] FMT_UNUSED = 2'd3;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [6:0]  field_index;
        logic [31:0] header_value;
        logic [15:0] sample_index;
        logic [31:0] sample_bits;
        logic [31:0] trace_index;
        logic        end_of_trace;
        logic        last_of_item;
    } res_t;

    typedef struct packed {
        logic       valid;
        logic       pair;
        logic [6:0] field;
    } hdr_map_t;

    function automatic logic [4:0] msb_pos(input logic [31:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 1; i < 32; i++)
        begin
            if (v[i])
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    // shift right rounding to nearest even
    function automatic logic [31:0] shr_rne(input logic [31:0] v, input logic [4:0] s);
        logic [31:0] q;
        logic [31:0] mask;
        logic [31:0] rem;
        logic [31:0] half;
        q    = v >> s;
        mask = (32'd1 << s) - 32'd1;
        rem  = v & mask;
        half = (s == 5'd0) ? 32'd0 : (32'd1 << (s - 5'd1));
        if (s != 5'd0 && (rem > half || (rem == half && q[0])))
        begin
            q = q + 32'd1;
        end
        return q;
    endfunction

    function automatic logic [31:0] ibm_to_ieee(input logic [31:0] w);
        logic [31:0] sign;
        logic [6:0]  ex;
        logic [31:0] m;
        logic [4:0]  p;
        logic signed [10:0] biased;
        logic signed [10:0] s;
        logic [31:0] r;
        sign   = {w[31], 31'd0};
        ex     = w[30:24];
        m      = {8'd0, w[23:0]};
        p      = msb_pos(m);
        biased = 11'(signed'({6'd0, p})) + 11'(signed'({2'd0, ex, 2'd0})) - 11'sd153;
        s      = 11'sd131 - 11'(signed'({2'd0, ex, 2'd0}));
        if (m == 32'd0)
        begin
            r = sign;
        end
        else if (biased >= 11'sd255)
        begin
            r = sign | 32'h7F80_0000;
        end
        else if (biased >= 11'sd1)
        begin
            r = sign | (({21'd0, 11'(biased - 11'sd1)} << 23) + (m << (5'd23 - p)));
        end
        else if (s < 11'sd0)
        begin
            r = sign | (m << 5'(-s));
        end
        else if (s >= 11'sd26)
        begin
            r = sign;
        end
        else
        begin
            r = sign | shr_rne(m, 5'(s));
        end
        return r;
    endfunction

    function automatic logic [31:0] int_to_ieee(input logic [31:0] w);
        logic [31:0] mag;
        logic [31:0] sig;
        logic [4:0]  p;
        logic [31:0] r;
        mag = w[31] ? (32'd0 - w) : w;
        p   = msb_pos(mag);
        if (p <= 5'd23)
        begin
            sig = mag << (5'd23 - p);
        end
        else
        begin
            sig = shr_rne(mag, p - 5'd23);
        end
        if (mag == 32'd0)
        begin
            r = 32'd0;
        end
        else
        begin
            r = {w[31], 31'd0} | (({24'd0, 8'({3'd0, p} + 8'd126)} << 23) + sig);
        end
        return r;
    endfunction

    function automatic hdr_map_t hdr_map(input logic [5:0] pos);
        hdr_map_t h;
        h.valid = 1'b1;
        h.pair  = 1'b0;
        h.field = 7'd0;
        priority if (pos <= 6'd6)
        begin
            h.field = {1'b0, pos};
        end
        else if (pos <= 6'd8)
        begin
            h.pair  = 1'b1;
            h.field = 7'd7 + {pos - 6'd7, 1'b0};
        end
        else if (pos <= 6'd16)
        begin
            h.field = {1'b0, pos} + 7'd2;
        end
        else if (pos == 6'd17)
        begin
            h.pair  = 1'b1;
            h.field = 7'd19;
        end
        else if (pos <= 6'd21)
        begin
            h.field = {1'b0, pos} + 7'd3;
        end
        else if (pos <= 6'd44)
        begin
            h.pair  = 1'b1;
            h.field = 7'd25 + {pos - 6'd22, 1'b0};
        end
        else if (pos <= 6'd49)
        begin
            h.field = {1'b0, pos} + 7'd26;
        end
        else if (pos == 6'd50)
        begin
            h.pair  = 1'b1;
            h.field = 7'd76;
        end
        else
        begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

### hw/rtl/segy_in_if.sv
// ----------------------------------------------------------------------------
// segy_in_if
// file word channel
// ----------------------------------------------------------------------------
interface segy_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] file_word;

    modport source (output valid, output file_word, input ready);
    modport sink   (input valid, input file_word, output ready);
endinterface

### hw/rtl/segy_out_if.sv
// ----------------------------------------------------------------------------
// segy_out_if
// decoded result channel
// ----------------------------------------------------------------------------
interface segy_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [6:0]  field_index;
    logic signed [31:0] header_value;
    logic [15:0] sample_index;
    logic [31:0] sample_bits;
    logic [31:0] trace_index;
    logic        end_of_trace;
    logic        last_of_item;

    modport source (output valid, output kind, output field_index, output header_value,
                    output sample_index, output sample_bits, output trace_index,
                    output end_of_trace, output last_of_item, input ready);
    modport sink   (input valid, input kind, input field_index, input header_value,
                    input sample_index, input sample_bits, input trace_index,
                    input end_of_trace, input last_of_item, output ready);
endinterface

### hw/rtl/segy_trace_word_decoder.sv
// ----------------------------------------------------------------------------
// segy_trace_word_decoder
// decodes seg-y trace records, one 32-bit file word per input transfer
// ----------------------------------------------------------------------------
// in_ch carries file words: 60 header words then samples_per_trace samples.
// out_ch carries results: header fields (kind 0) and converted samples (kind 1).
// cfg_we/cfg_index/cfg_wdata write big_endian, sample_format and
// samples_per_trace; write only while the block is idle.
// a word is decoded in the cycle it is accepted and its results sit in a
// two-entry result register, so the first result is presented from the next cycle.
// words giving one or no result are taken every cycle while out_ch is ready; a
// word giving two header fields holds off the next word until its first field has
// gone, as the single output port drains the result register one result per transfer.
// reset clears the word position, trace count and result count (the result slots
// keep their contents) and restores the register defaults (big endian, ibm float, one sample).
// when out_ch stalls, the held result stays put and in_ch is held off
// once the result register cannot take the next word's results.
// ----------------------------------------------------------------------------
module segy_trace_word_decoder
    import segy_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    segy_in_if.sink     in_ch,
    segy_out_if.source  out_ch
);

    logic               big_endian_reg;
    logic [1:0]         sample_format_reg;
    logic [15:0]        samples_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [31:0]        trace_reg;
    logic [31:0]        trace_next;
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    res_t               slot0_reg;
    res_t               slot0_next;
    res_t               slot1_reg;
    res_t               slot1_next;

    logic               in_xfer;
    logic               out_xfer;
    logic [31:0]        w;
    hdr_map_t           hm;
    logic [15:0]        first_h;
    logic [15:0]        second_h;
    logic [15:0]        n_eff;
    logic [POS_W-1:0]   idx;
    logic               eot;
    logic [31:0]        sbits;
    res_t               r0;
    res_t               r1;
    logic [1:0]         nres;
    logic [1:0]         remain;

    assign in_ch.ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ch.ready);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_xfer    = out_ch.valid && out_ch.ready;

    always_comb
    begin
        w        = big_endian_reg ? in_ch.file_word :
                   {in_ch.file_word[7:0], in_ch.file_word[15:8],
                    in_ch.file_word[23:16], in_ch.file_word[31:24]};
        hm       = hdr_map(pos_reg[5:0]);
        first_h  = big_endian_reg ? w[31:16] : w[15:0];
        second_h = big_endian_reg ? w[15:0] : w[31:16];
        n_eff    = (samples_reg == 16'd0) ? 16'd1 : samples_reg;
        idx      = pos_reg - POS_W'(HDR_WORDS);
        eot      = idx >= POS_W'(n_eff - 16'd1);
        unique case (sample_format_reg)
            FMT_IBM:  sbits = ibm_to_ieee(w);
            FMT_INT:  sbits = int_to_ieee(w);
            FMT_IEEE: sbits = w;
            default:  sbits = 32'd0;
        endcase

        r0 = '0;
        r1 = '0;
        r0.trace_index = trace_reg;
        r1.trace_index = trace_reg;
        pos_next   = pos_reg;
        trace_next = trace_reg;
        nres       = 2'd0;
        if (pos_reg < POS_W'(HDR_WORDS))
        begin
            pos_next       = pos_reg + POS_W'(1);
            r0.kind        = KIND_HEADER;
            r0.field_index = hm.field;
            r1.kind        = KIND_HEADER;
            r1.field_index = hm.field + 7'd1;
            r1.header_value = {{16{second_h[15]}}, second_h};
            r1.last_of_item = 1'b1;
            if (!hm.valid)
            begin
                nres = 2'd0;
            end
            else if (hm.pair)
            begin
                nres            = 2'd2;
                r0.header_value = {{16{first_h[15]}}, first_h};
            end
            else
            begin
                nres            = 2'd1;
                r0.header_value = w;
                r0.last_of_item = 1'b1;
            end
        end
        else
        begin
            nres            = 2'd1;
            r0.kind         = KIND_SAMPLE;
            r0.sample_index = idx[15:0];
            r0.sample_bits  = sbits;
            r0.end_of_trace = eot;
            r0.last_of_item = 1'b1;
            if (eot)
            begin
                pos_next   = '0;
                trace_next = trace_reg + 32'd1;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_comb
    begin
        remain     = cnt_reg - {1'b0, out_xfer};
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = remain;
        if (out_xfer && cnt_reg == 2'd2)
        begin
            slot0_next = slot1_reg;
        end
        if (in_xfer)
        begin
            slot0_next = r0;
            slot1_next = r1;
            cnt_next   = nres;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_endian_reg    <= 1'b1;
            sample_format_reg <= FMT_IBM;
            samples_reg       <= 16'd1;
            pos_reg           <= '0;
            trace_reg         <= '0;
            cnt_reg           <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BIG_ENDIAN: big_endian_reg    <= cfg_wdata[0];
                    CFG_SAMPLE_FMT: sample_format_reg <= cfg_wdata[1:0];
                    CFG_SAMPLES:    samples_reg       <= cfg_wdata;
                    default:        ;
                endcase
            end
            if (in_xfer)
            begin
                pos_reg   <= pos_next;
                trace_reg <= trace_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign out_ch.valid        = cnt_reg != 2'd0;
    assign out_ch.kind         = slot0_reg.kind;
    assign out_ch.field_index  = slot0_reg.field_index;
    assign out_ch.header_value = slot0_reg.header_value;
    assign out_ch.sample_index = slot0_reg.sample_index;
    assign out_ch.sample_bits  = slot0_reg.sample_bits;
    assign out_ch.trace_index  = slot0_reg.trace_index;
    assign out_ch.end_of_trace = slot0_reg.end_of_trace;
    assign out_ch.last_of_item = slot0_reg.last_of_item;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result count out of range");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> cnt_reg != 2'd2)
        else $error("word accepted with result register full");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !slot0_reg.last_of_item && slot1_reg.last_of_item)
        else $error("pair results out of order");

    a_pair_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && out_xfer) |=> cnt_reg == 2'd1 && out_ch.last_of_item)
        else $error("second field of pair lost");

endmodule

### test/segy_trace_word_decoder_test.sv
// ----------------------------------------------------------------------------
// segy_trace_word_decoder_test
// self-checking regression for the seg-y trace word decoder: file words are
// sent with random gaps in most tests, header fields and converted samples are
// predicted per accepted word and compared field by field against the result stream
// ----------------------------------------------------------------------------
module segy_trace_word_decoder_test;
    import segy_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    segy_in_if  in_ch ();
    segy_out_if out_ch ();

    segy_trace_word_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    logic        big_endian_q;
    logic [1:0]  sample_fmt_q;
    logic [15:0] samples_q;
    logic [16:0] word_pos_q;
    logic [31:0] trace_count_q;

    res_t        decoded_q[$];
    int          failures;
    int          cycle_count;
    bit          src_gaps;
    bit          sink_stalls;
    int          hold_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("segy_trace_word_decoder regression: fail");
            $finish;
        end
    end

    function automatic logic [4:0] top_bit(input logic [31:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 31; i > 0; i--)
        begin
            if (v[i] && p == 5'd0)
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [31:0] round_shift(input logic [31:0] v, input int s);
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] half;
        if (s <= 0)
        begin
            return v;
        end
        q    = v >> s;
        rem  = v & ((32'd1 << s) - 32'd1);
        half = 32'd1 << (s - 1);
        if (rem > half || (rem == half && q[0]))
        begin
            q = q + 32'd1;
        end
        return q;
    endfunction

    function automatic logic [31:0] hex_float_bits(input logic [31:0] w);
        logic [31:0] sgn;
        logic [31:0] m;
        int          ex;
        int          p;
        int          biased;
        int          s;
        sgn = {w[31], 31'd0};
        ex  = int'(w[30:24]);
        m   = {8'd0, w[23:0]};
        if (m == 32'd0)
        begin
            return sgn;
        end
        p      = int'(top_bit(m));
        biased = p + 4 * ex - 153;
        if (biased >= 255)
        begin
            return sgn | 32'h7F80_0000;
        end
        if (biased >= 1)
        begin
            return sgn | ((32'(biased - 1) << 23) + (m << (23 - p)));
        end
        s = 131 - 4 * ex;
        if (s < 0)
        begin
            return sgn | (m << (-s));
        end
        if (s >= 26)
        begin
            return sgn;
        end
        return sgn | round_shift(m, s);
    endfunction

    function automatic logic [31:0] int_float_bits(input logic [31:0] w);
        logic [31:0] mag;
        logic [31:0] sig;
        int          p;
        mag = w[31] ? (32'd0 - w) : w;
        if (mag == 32'd0)
        begin
            return 32'd0;
        end
        p   = int'(top_bit(mag));
        sig = (p <= 23) ? (mag << (23 - p)) : round_shift(mag, p - 23);
        return {w[31], 31'd0} | ((32'(p + 126) << 23) + sig);
    endfunction

    function automatic res_t header_field(input logic [6:0] f, input logic [31:0] v,
                                          input logic last);
        res_t r;
        r              = '0;
        r.kind         = KIND_HEADER;
        r.field_index  = f;
        r.header_value = v;
        r.trace_index  = trace_count_q;
        r.last_of_item = last;
        return r;
    endfunction

    task automatic decode_word(input logic [31:0] raw);
        logic [31:0] w;
        logic [31:0] n;
        logic [31:0] idx;
        logic [6:0]  f;
        logic [15:0] first;
        logic [15:0] second;
        bit          pair;
        bit          none;
        res_t        r;
        int          p;
        w    = big_endian_q ? raw : {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
        p    = int'(word_pos_q);
        pair = 0;
        none = 0;
        f    = '0;
        if (p < HDR_WORDS)
        begin
            word_pos_q = word_pos_q + 17'd1;
            if (p <= 6) f = 7'(p);
            else if (p <= 8) begin f = 7'(7 + 2 * (p - 7)); pair = 1; end
            else if (p <= 16) f = 7'(p + 2);
            else if (p == 17) begin f = 7'd19; pair = 1; end
            else if (p <= 21) f = 7'(p + 3);
            else if (p <= 44) begin f = 7'(25 + 2 * (p - 22)); pair = 1; end
            else if (p <= 49) f = 7'(p + 26);
            else if (p == 50) begin f = 7'd76; pair = 1; end
            else none = 1;
            if (none)
            begin
                return;
            end
            if (!pair)
            begin
                decoded_q.push_back(header_field(f, w, 1'b1));
                return;
            end
            first  = big_endian_q ? w[31:16] : w[15:0];
            second = big_endian_q ? w[15:0] : w[31:16];
            decoded_q.push_back(header_field(f, {{16{first[15]}}, first}, 1'b0));
            decoded_q.push_back(header_field(f + 7'd1, {{16{second[15]}}, second}, 1'b1));
            return;
        end
        n            = (samples_q == 16'd0) ? 32'd1 : {16'd0, samples_q};
        idx          = 32'(word_pos_q) - HDR_WORDS;
        r            = '0;
        r.kind       = KIND_SAMPLE;
        r.sample_index = idx[15:0];
        case (sample_fmt_q)
            FMT_IBM:  r.sample_bits = hex_float_bits(w);
            FMT_INT:  r.sample_bits = int_float_bits(w);
            FMT_IEEE: r.sample_bits = w;
            default:  r.sample_bits = 32'd0;
        endcase
        r.trace_index  = trace_count_q;
        r.end_of_trace = (idx >= n - 32'd1);
        r.last_of_item = 1'b1;
        decoded_q.push_back(r);
        if (r.end_of_trace)
        begin
            word_pos_q    = '0;
            trace_count_q = trace_count_q + 32'd1;
        end
        else
        begin
            word_pos_q = word_pos_q + 17'd1;
        end
    endtask

    // input transfers feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            decode_word(in_ch.file_word);
        end
    end

    // result check
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("unexpected result transfer");
                failures++;
            end
            else
            begin
                e = decoded_q.pop_front();
                if (out_ch.kind !== e.kind)
                begin
                    $error("kind exp %0d got %0d", e.kind, out_ch.kind);
                    failures++;
                end
                if (out_ch.field_index !== e.field_index)
                begin
                    $error("field_index exp %0d got %0d", e.field_index, out_ch.field_index);
                    failures++;
                end
                if (out_ch.header_value !== e.header_value)
                begin
                    $error("header_value exp %h got %h", e.header_value, out_ch.header_value);
                    failures++;
                end
                if (out_ch.sample_index !== e.sample_index)
                begin
                    $error("sample_index exp %0d got %0d", e.sample_index, out_ch.sample_index);
                    failures++;
                end
                if (out_ch.sample_bits !== e.sample_bits)
                begin
                    $error("sample_bits exp %h got %h", e.sample_bits, out_ch.sample_bits);
                    failures++;
                end
                if (out_ch.trace_index !== e.trace_index)
                begin
                    $error("trace_index exp %0d got %0d", e.trace_index, out_ch.trace_index);
                    failures++;
                end
                if (out_ch.end_of_trace !== e.end_of_trace)
                begin
                    $error("end_of_trace exp %0d got %0d", e.end_of_trace,
                           out_ch.end_of_trace);
                    failures++;
                end
                if (out_ch.last_of_item !== e.last_of_item)
                begin
                    $error("last_of_item exp %0d got %0d", e.last_of_item,
                           out_ch.last_of_item);
                    failures++;
                end
            end
        end
    end

    // receiver readiness
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles  <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= !(sink_stalls && $urandom_range(99) < 17);
        end
    end

    // valid stays high after a transfer so words can follow back to back
    task automatic send_word(input logic [31:0] w);
        while (src_gaps && $urandom_range(99) < 17)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.file_word <= w;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // writes only once drained
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BIG_ENDIAN: big_endian_q = v[0];
            CFG_SAMPLE_FMT: sample_fmt_q = v[1:0];
            CFG_SAMPLES:    samples_q    = v;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] random_sample;
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(5))
            0: w[30:24] = 7'($urandom_range(127, 120));
            1: w[30:24] = 7'($urandom_range(40));
            2: w[23:0]  = 24'($urandom_range(3));
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_header;
        for (int i = 0; i < HDR_WORDS; i++)
        begin
            send_word($urandom);
        end
    endtask

    task automatic test_directed;
        logic [31:0] edge_words[10];
        edge_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h4110_0000, 32'hC276_A000, 32'h7FFF_FFFF, 32'h0000_0001,
                       32'h8100_0001, 32'h2000_0003};
        write_reg(CFG_SAMPLES, 16'd10);
        for (int i = 0; i < HDR_WORDS; i++)
        begin
            send_word((i % 2) ? 32'h8000_7FFF : 32'h7FFF_8000);
        end
        foreach (edge_words[i])
        begin
            send_word(edge_words[i]);
        end
        write_reg(CFG_SAMPLE_FMT, 16'(FMT_INT));
        write_reg(CFG_SAMPLES, 16'd0);
        send_header();
        send_word(32'h8000_0000);
        write_reg(CFG_SAMPLE_FMT, 16'(FMT_UNUSED));
        send_header();
        send_word(32'h1234_5678);
    endtask

    task automatic test_random_traces;
        for (int t = 0; t < 24; t++)
        begin
            write_reg(CFG_BIG_ENDIAN, 16'($urandom_range(1)));
            write_reg(CFG_SAMPLE_FMT, 16'($urandom_range(3)));
            write_reg(CFG_SAMPLES, (t == 5) ? 16'hFFFF : 16'($urandom_range(20, 1)));
            src_gaps    = (t % 6) != 3;
            sink_stalls = (t % 6) != 3;
            send_header();
            if (t == 5)
            begin
                // largest count: header and three samples, trace finished after a count change
                repeat (3) send_word(random_sample());
                write_reg(CFG_SAMPLES, 16'd2);
                send_word(random_sample());
            end
            else
            begin
                for (int s = 0; s < int'(samples_q); s++)
                begin
                    send_word(random_sample());
                end
            end
        end
    endtask

    task automatic test_backpressure;
        write_reg(CFG_SAMPLES, 16'd8);
        hold_cycles = 200;
        src_gaps    = 0;
        send_header();
        repeat (8) send_word(random_sample());
        drain();
        repeat (20) send_word(random_sample());
        write_reg(CFG_SAMPLES, 16'd65535);
        write_reg(CFG_SAMPLES, 16'd1);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.file_word = '0;
        out_ch.ready   = 1'b0;
        failures       = 0;
        cycle_count    = 0;
        hold_cycles    = 0;
        src_gaps       = 1;
        sink_stalls    = 1;
        big_endian_q   = 1'b1;
        sample_fmt_q   = FMT_IBM;
        samples_q      = 16'd1;
        word_pos_q     = '0;
        trace_count_q  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traces();
        test_backpressure();
        drain();
        repeat (20) @(posedge clk);
        if (failures == 0 && decoded_q.size() == 0)
        begin
            $display("segy_trace_word_decoder regression: pass");
        end
        else
        begin
            $display("segy_trace_word_decoder regression: fail");
        end
        $finish;
    end

endmodule
